@@ hw/rtl/bba_pkg.sv @@
`default_nettype none

package bba_pkg;

	localparam int MAP_BITS_DEF  = 8192;
	localparam int WORD_BITS_DEF = 64;

	// Item numbers are 16 bits wide, so a usable bit count never exceeds 65536.
	localparam int NUM_W    = 16;
	localparam int ACTIVE_W = 14;
	localparam int CFG_W    = 16;
	localparam int LIM_W    = 17;
	localparam int OFF_W    = 18;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RST = ACTIVE_W'(8192);

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_MARK  = 2'd2;

	localparam logic CFG_BASE   = 1'b0;
	localparam logic CFG_ACTIVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

endpackage

`default_nettype wire

@@ hw/rtl/bba_map_ram.sv @@
`default_nettype none

module bba_map_ram #(
	parameter int WORD_BITS = 64,
	parameter int DEPTH     = 128,
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bba_div.sv @@
`default_nettype none

module bba_div
	import bba_pkg::*;
#(
	parameter int WORD_BITS = 64,
	localparam int BI_W     = $clog2(WORD_BITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] dividend,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [BI_W-1:0]  rem
);

	localparam int SH  = NUM_W + BI_W;
	localparam int M_W = NUM_W + 1;
	localparam int P_W = NUM_W + M_W;
	localparam logic [M_W-1:0] RECIP = M_W'((2**SH + WORD_BITS - 1) / WORD_BITS);

	logic             done_q;
	logic [NUM_W-1:0] quot_q;
	logic [BI_W-1:0]  rem_q;
	logic [P_W-1:0]   prod;
	logic [NUM_W-1:0] q;
	logic [NUM_W-1:0] back;

	// Division by the word size through multiplication by its rounded-up
	// reciprocal; the shift is wide enough to be exact for every 16-bit dividend.
	always_comb begin
		prod = P_W'(dividend) * P_W'(RECIP);
		q    = NUM_W'(prod >> SH);
		back = dividend - q * NUM_W'(WORD_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			quot_q <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= go;
			if (go) begin
				quot_q <= q;
				rem_q  <= back[BI_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_block_allocator.sv @@
// Channel   Signals                                     Direction  Handshake
// command   start, action, item_number                  in         start && !busy
// result    done, granted_number, status                out        done, one cycle
// config    cfg_we, cfg_index, cfg_wdata                in         cfg_we, no wait
//
// An allocate reads one map word per cycle until it finds a free bit below the limit
// or reaches the limit. Free and mark divide by the word size through a reciprocal
// multiply, then do a read-modify-write of one word. Out-of-range requests and an
// allocate with no usable bits answer in the cycle after they are accepted.
// After reset the map is swept to zero, one word a cycle, with
// busy high; configuration writes are taken during the sweep.
// The receiver cannot stall: each result shows for one cycle with done.
`default_nettype none

module bitmap_block_allocator
	import bba_pkg::*;
#(
	parameter int MAP_BITS  = MAP_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       action,
	input  logic [NUM_W-1:0] item_number,
	output logic             done,
	output logic [NUM_W-1:0] granted_number,
	output logic [1:0]       status,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BI_W      = $clog2(WORD_BITS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DIV,
		S_FRD,
		S_FMOD
	} state_t;

	state_t                state_q;
	logic [NUM_W-1:0]      base_q;
	logic [ACTIVE_W-1:0]   active_q;
	logic [WA_W-1:0]       clr_w_q;
	logic [WA_W-1:0]       rd_w_q;
	logic [OFF_W-1:0]      rd_off_q;
	logic                  v_s1;
	logic [WA_W-1:0]       addr_s1;
	logic [OFF_W-1:0]      off_s1;
	logic                  mark_q;
	logic                  done_q;
	logic [NUM_W-1:0]      granted_q;
	status_t               status_q;

	logic [LIM_W-1:0]      room;
	logic [LIM_W-1:0]      limit;
	logic                  accept;
	logic [NUM_W-1:0]      diff;
	logic                  in_region;
	logic [OFF_W-1:0]      rem_bits;
	logic                  hit;
	logic [BI_W-1:0]       hit_idx;
	logic [WORD_BITS-1:0]  hit_hot;
	logic [WORD_BITS-1:0]  mod_hot;
	logic [OFF_W-1:0]      grant_off;
	logic                  more;

	logic                  mem_we;
	logic [WA_W-1:0]       mem_waddr;
	logic [WORD_BITS-1:0]  mem_wdata;
	logic                  mem_re;
	logic [WA_W-1:0]       mem_raddr;
	logic [WORD_BITS-1:0]  mem_rdata;

	logic                  div_go;
	logic                  div_done;
	logic [NUM_W-1:0]      div_quot;
	logic [BI_W-1:0]       div_rem;

	bba_map_ram #(
		.WORD_BITS(WORD_BITS),
		.DEPTH    (MAP_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	bba_div #(
		.WORD_BITS(WORD_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.dividend(diff),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	// Usable bit count: active count, capped by the map size and by the room
	// left below item number 65536.
	always_comb begin
		room  = LIM_W'(17'h10000) - {1'b0, base_q};
		limit = LIM_W'(active_q);
		if (limit > LIM_W'(MAP_BITS)) begin
			limit = LIM_W'(MAP_BITS);
		end
		if (limit > room) begin
			limit = room;
		end
	end

	assign accept    = start && (state_q == S_IDLE);
	assign diff      = item_number - base_q;
	assign in_region = (item_number >= base_q) && ({1'b0, diff} < limit);
	assign div_go    = accept && (action == ACT_FREE || action == ACT_MARK) && in_region;

	// Lowest free bit of the word just read that still lies below the limit.
	always_comb begin
		rem_bits = OFF_W'(limit) - off_s1;
		hit      = 1'b0;
		hit_idx  = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!mem_rdata[b] && (OFF_W'(b) < rem_bits)) begin
				hit     = 1'b1;
				hit_idx = BI_W'(b);
			end
		end
	end

	assign hit_hot   = WORD_BITS'(1) << hit_idx;
	assign mod_hot   = WORD_BITS'(1) << div_rem;
	assign grant_off = off_s1 + OFF_W'(hit_idx);
	assign more      = rd_off_q < OFF_W'(limit);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = mem_rdata | hit_hot;
		mem_re    = 1'b0;
		mem_raddr = rd_w_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_w_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				mem_re    = accept && (action == ACT_ALLOC) && (limit != '0);
				mem_raddr = '0;
			end
			S_SCAN: begin
				mem_we = v_s1 && hit;
				mem_re = !(v_s1 && hit) && v_s1 && more;
			end
			S_FRD: begin
				mem_re    = 1'b1;
				mem_raddr = div_quot[WA_W-1:0];
			end
			S_FMOD: begin
				mem_we    = 1'b1;
				mem_waddr = div_quot[WA_W-1:0];
				mem_wdata = mark_q ? (mem_rdata | mod_hot) : (mem_rdata & ~mod_hot);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			active_q <= ACTIVE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE:   base_q   <= cfg_wdata;
				CFG_ACTIVE: active_q <= cfg_wdata[ACTIVE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_w_q   <= '0;
			rd_w_q    <= '0;
			rd_off_q  <= '0;
			v_s1      <= 1'b0;
			addr_s1   <= '0;
			off_s1    <= '0;
			mark_q    <= 1'b0;
			done_q    <= 1'b0;
			granted_q <= '0;
			status_q  <= ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_w_q <= clr_w_q + 1'b1;
					if (clr_w_q == WA_W'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						mark_q <= (action == ACT_MARK);
						if (action == ACT_ALLOC) begin
							if (limit == '0) begin
								done_q    <= 1'b1;
								granted_q <= '0;
								status_q  <= ST_FULL;
							end else begin
								// Word zero is being read in this cycle.
								v_s1     <= 1'b1;
								addr_s1  <= '0;
								off_s1   <= '0;
								rd_w_q   <= WA_W'(1);
								rd_off_q <= OFF_W'(WORD_BITS);
								state_q  <= S_SCAN;
							end
						end else if (div_go) begin
							state_q <= S_DIV;
						end else begin
							done_q    <= 1'b1;
							granted_q <= '0;
							status_q  <= ST_RANGE;
						end
					end
				end
				S_SCAN: begin
					if (v_s1 && hit) begin
						v_s1      <= 1'b0;
						done_q    <= 1'b1;
						granted_q <= base_q + grant_off[NUM_W-1:0];
						status_q  <= ST_OK;
						state_q   <= S_IDLE;
					end else if (!v_s1) begin
						done_q    <= 1'b1;
						granted_q <= '0;
						status_q  <= ST_FULL;
						state_q   <= S_IDLE;
					end else if (more) begin
						v_s1     <= 1'b1;
						addr_s1  <= rd_w_q;
						off_s1   <= rd_off_q;
						rd_w_q   <= rd_w_q + 1'b1;
						rd_off_q <= rd_off_q + OFF_W'(WORD_BITS);
					end else begin
						v_s1 <= 1'b0;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					state_q <= S_FMOD;
				end
				S_FMOD: begin
					done_q    <= 1'b1;
					granted_q <= '0;
					status_q  <= ST_OK;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign granted_number = granted_q;
	assign status         = status_q;

endmodule

`default_nettype wire

@@ hw/rtl/bba_checker.sv @@
`default_nettype none

module bba_checker
	import bba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             done,
	input  logic [NUM_W-1:0] granted_number,
	input  logic [1:0]       status
);

	// Only a successful allocate carries a nonzero number.
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> granted_number == '0)
		else $error("granted number nonzero on a failed transaction");

	// An accepted command is either worked on or answered in the next cycle.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted command neither busy nor answered");

	// No result appears without a command in progress or just accepted.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without a command");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.granted_number(granted_number),
	.status        (status)
);

`default_nettype wire
